// ===== sv/crcp_pkg.sv =====
`default_nettype none

package crcp_pkg;

    localparam int MAX_DEGREE  = 16;
    // Widest degree that the polynomial register can carry.
    localparam int DEG_CAP     = (MAX_DEGREE < 16) ? MAX_DEGREE : 16;

    localparam int BYTE_W      = 8;
    localparam int NIB_W       = 4;
    localparam int POLY_W      = 17;
    localparam int DEG_W       = 5;
    localparam int CRC_W       = 16;
    localparam int MOD8_W      = 3;
    localparam int CFG_IDX_W   = 2;
    localparam int CFG_DATA_W  = 17;

    // Bit stream of one item: header (8 + up to 7 pad) plus up to two codewords.
    localparam int STREAM_W    = 64;
    localparam int SEG_LEN_W   = 6;
    localparam int ACC_CNT_W   = 7;
    // Up to 7 held bits plus the longest item stream.
    localparam int MAX_BITS    = 62;

    localparam int QUEUE_DEPTH = 2;

    localparam logic [CFG_IDX_W-1:0] CFG_GEN_POLY   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_GEN_DEGREE = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_DW_MODE    = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_MSG_MOD8   = 2'd3;

    typedef struct packed {
        logic [POLY_W-1:0] gen_poly;
        logic [DEG_W-1:0]  gen_degree;
        logic              dataword_mode;
        logic [MOD8_W-1:0] msg_bytes_mod8;
    } t_cfg;

    // One item's bits, MSB aligned, zeros below nbits.
    typedef struct packed {
        logic [STREAM_W-1:0]  bits;
        logic [SEG_LEN_W-1:0] nbits;
    } t_seg;

    typedef struct packed {
        logic [ACC_CNT_W-1:0] bit_cnt;
    } t_bstat;

    // Serial CRC over a 4- or 8-bit word, MSB first. Only the low d bits of
    // the generator matter; the leading term only clears a discarded bit.
    function automatic logic [CRC_W-1:0] crc_calc(
        input logic [BYTE_W-1:0] word,
        input logic              nib,
        input logic [DEG_W-1:0]  d,
        input logic [POLY_W-1:0] poly
    );
        logic [CRC_W:0]   wide_mask;
        logic [CRC_W-1:0] mask;
        logic [CRC_W-1:0] gp;
        logic [CRC_W-1:0] rem;
        logic             top;
        logic             fb;
        wide_mask = ({{CRC_W{1'b0}}, 1'b1} << d) - {{CRC_W{1'b0}}, 1'b1};
        mask      = wide_mask[CRC_W-1:0];
        gp        = poly[CRC_W-1:0] & mask;
        rem       = '0;
        for (int i = BYTE_W - 1; i >= 0; i--) begin
            top = (d != '0) ? rem[4'(d - 5'd1)] : 1'b0;
            fb  = word[i] ^ top;
            if (!nib || i < NIB_W) begin
                rem = ((rem << 1) & mask) ^ (fb ? gp : '0);
            end
        end
        return rem;
    endfunction

endpackage

`default_nettype wire

// ===== sv/crcp_front.sv =====
`default_nettype none

module crcp_front
    import crcp_pkg::*;
(
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire t_cfg              i_cfg,
    input  wire logic              i_valid,
    input  wire logic [BYTE_W-1:0] i_data,
    output logic                   o_ready,
    input  wire logic              i_full,
    output logic                   o_push,
    output t_seg                   o_seg
);

    typedef struct packed {
        logic [BYTE_W-1:0] data;
        logic [CRC_W-1:0]  crc0;
        logic [CRC_W-1:0]  crc1;
        logic [DEG_W-1:0]  d;
        logic              mode;
        logic              hdr;
        logic [2:0]        pad;
    } t_item;

    logic  r_hdr_pend;
    logic  r_s1_valid;
    t_item r_it;
    t_item n_it;

    logic              accept;
    logic [DEG_W-1:0]  d_eff;
    logic [2:0]        kd3;
    logic [5:0]        prod;
    logic [2:0]        bits3;

    logic [CRC_W-1:0]  top0;
    logic [CRC_W-1:0]  top1;
    logic [23:0]       cw0;
    logic [23:0]       cw1;
    logic [DEG_W-1:0]  len0;
    logic [DEG_W-1:0]  len1;
    logic [39:0]       payload;
    logic [SEG_LEN_W-1:0] plen;
    logic [3:0]        hlen;
    logic [STREAM_W-1:0] pl_wide;

    assign o_ready = !r_s1_valid || !i_full;
    assign o_push  = r_s1_valid && !i_full;
    assign accept  = i_valid && o_ready;

    // Classify: effective degree, CRCs and the leading pad count.
    always_comb begin
        d_eff = (i_cfg.gen_degree > DEG_W'(DEG_CAP)) ? DEG_W'(DEG_CAP) : i_cfg.gen_degree;
        kd3   = i_cfg.dataword_mode ? d_eff[2:0] : {d_eff[1:0], 1'b0};
        prod  = {3'b000, i_cfg.msg_bytes_mod8} * {3'b000, kd3};
        bits3 = prod[2:0];
        n_it.data = i_data;
        n_it.d    = d_eff;
        n_it.mode = i_cfg.dataword_mode;
        n_it.hdr  = r_hdr_pend;
        n_it.pad  = 3'd0 - bits3;
        if (i_cfg.dataword_mode) begin
            n_it.crc0 = crc_calc(i_data, 1'b0, d_eff, i_cfg.gen_poly);
            n_it.crc1 = '0;
        end else begin
            n_it.crc0 = crc_calc({4'd0, i_data[7:4]}, 1'b1, d_eff, i_cfg.gen_poly);
            n_it.crc1 = crc_calc({4'd0, i_data[3:0]}, 1'b1, d_eff, i_cfg.gen_poly);
        end
    end

    // Lay out header, pad and codewords MSB first.
    always_comb begin
        top0 = r_it.crc0 << (5'(CRC_W) - r_it.d);
        top1 = r_it.crc1 << (5'(CRC_W) - r_it.d);
        cw0  = r_it.mode ? {r_it.data, top0} : {r_it.data[7:4], top0, 4'b0000};
        cw1  = {r_it.data[3:0], top1, 4'b0000};
        len0 = (r_it.mode ? 5'd8 : 5'd4) + r_it.d;
        len1 = 5'd4 + r_it.d;
        payload = {cw0, 16'd0} | (r_it.mode ? 40'd0 : ({cw1, 16'd0} >> len0));
        plen = SEG_LEN_W'(len0) + (r_it.mode ? '0 : SEG_LEN_W'(len1));
        hlen = r_it.hdr ? (4'd8 + {1'b0, r_it.pad}) : 4'd0;
        pl_wide = {payload, 24'd0};
        o_seg.bits  = {(r_it.hdr ? {5'd0, r_it.pad} : 8'd0), 56'd0} | (pl_wide >> hlen);
        o_seg.nbits = SEG_LEN_W'(hlen) + plen;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hdr_pend <= 1'b1;
            r_s1_valid <= 1'b0;
        end else begin
            if (accept) begin
                r_s1_valid <= 1'b1;
                r_hdr_pend <= 1'b0;
            end else if (o_push) begin
                r_s1_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_it <= n_it;
        end
    end

endmodule

`default_nettype wire

// ===== sv/crcp_fifo.sv =====
`default_nettype none

module crcp_fifo
    import crcp_pkg::*;
(
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_push,
    input  wire t_seg i_wdata,
    input  wire logic i_pop,
    output t_seg      o_rdata,
    output logic      o_full,
    output logic      o_empty
);

    localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;

    t_seg             r_mem [QUEUE_DEPTH];
    logic [PTR_W-1:0] r_wr_ptr;
    logic [PTR_W-1:0] r_rd_ptr;
    logic [PTR_W:0]   r_count;

    assign o_full  = (r_count == (PTR_W + 1)'(QUEUE_DEPTH));
    assign o_empty = (r_count == '0);
    assign o_rdata = r_mem[r_rd_ptr];

    function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
        return (p == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : p + 1'b1;
    endfunction

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= ptr_inc(r_wr_ptr);
            end
            if (i_pop) begin
                r_rd_ptr <= ptr_inc(r_rd_ptr);
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + 1'b1;
            end else if (i_pop && !i_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_wdata;
        end
    end

endmodule

`default_nettype wire

// ===== sv/crcp_back.sv =====
`default_nettype none

module crcp_back
    import crcp_pkg::*;
(
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire t_seg       i_seg,
    input  wire logic       i_empty,
    output logic            o_pop,
    output logic            o_valid,
    input  wire logic       i_ready,
    output logic [BYTE_W-1:0] o_byte,
    output logic            o_last,
    output t_bstat          o_stat
);

    logic [STREAM_W-1:0]  r_sh;
    logic [ACC_CNT_W-1:0] r_cnt;
    logic                 r_ovalid;
    logic [BYTE_W-1:0]    r_obyte;
    logic                 r_olast;

    logic [STREAM_W-1:0]  n_sh;
    logic [ACC_CNT_W-1:0] n_cnt;
    logic [STREAM_W-1:0]  base_sh;
    logic [ACC_CNT_W-1:0] base_cnt;
    logic                 out_free;
    logic                 emit;
    logic                 load;

    always_comb begin
        out_free = !r_ovalid || i_ready;
        emit     = out_free && (r_cnt >= ACC_CNT_W'(BYTE_W));
        if (emit) begin
            base_sh  = r_sh << BYTE_W;
            base_cnt = r_cnt - ACC_CNT_W'(BYTE_W);
        end else begin
            base_sh  = r_sh;
            base_cnt = r_cnt;
        end
        // Next item joins the held bits once fewer than a byte remains.
        load = !i_empty && (base_cnt < ACC_CNT_W'(BYTE_W));
        if (load) begin
            n_sh  = base_sh | (i_seg.bits >> base_cnt);
            n_cnt = base_cnt + ACC_CNT_W'(i_seg.nbits);
        end else begin
            n_sh  = base_sh;
            n_cnt = base_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sh     <= '0;
            r_cnt    <= '0;
            r_ovalid <= 1'b0;
        end else begin
            r_sh  <= n_sh;
            r_cnt <= n_cnt;
            if (emit) begin
                r_ovalid <= 1'b1;
            end else if (i_ready) begin
                r_ovalid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (emit) begin
            r_obyte <= r_sh[STREAM_W-1 -: BYTE_W];
            r_olast <= (r_cnt < ACC_CNT_W'(2 * BYTE_W));
        end
    end

    assign o_pop          = load;
    assign o_valid        = r_ovalid;
    assign o_byte         = r_obyte;
    assign o_last         = r_olast;
    assign o_stat.bit_cnt = r_cnt;

endmodule

`default_nettype wire

// ===== sv/crc_codeword_packer.sv =====
`default_nettype none

// CRC codeword packer. Each accepted message byte is encoded as one 8-bit
// dataword or as two 4-bit datawords (high nibble first), each followed by
// its CRC remainder under the configured generator, and the codeword bits are
// packed MSB first into output bytes. The first word after reset is preceded
// by a header byte holding the pad count and that many zero bits, so that a
// message of the configured length ends byte aligned. m_axis_tlast marks the
// last output byte caused by an input byte; bits short of a full byte stay
// held for the next input. Timing: an input byte is captured with its CRCs,
// laid out into a two-entry queue, loaded into the bit accumulator and sent
// from an output register. The packer emits one output byte per cycle while
// the receiver is ready, and picks up the next queued item in the cycle it
// emits the last byte of the current one. An input byte yields 1 to 6 output
// bytes, two at the reset settings once the header is out. The output byte
// rate is the bound. Configure only while the block is idle; writes take
// effect with the next accepted byte.

module crc_codeword_packer
    import crcp_pkg::*;
(
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    // configuration write port
    input  wire logic                  i_cfg_we,
    input  wire logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  wire logic [CFG_DATA_W-1:0] i_cfg_wdata,
    // input words
    input  wire logic                  s_axis_tvalid,
    output logic                       s_axis_tready,
    input  wire logic [BYTE_W-1:0]     s_axis_tdata,   // [7:0] data_byte
    // output words
    output logic                       m_axis_tvalid,
    input  wire logic                  m_axis_tready,
    output logic [BYTE_W-1:0]          m_axis_tdata,   // [7:0] out_byte
    output logic                       m_axis_tlast    // run_last
);

    t_cfg   r_cfg;
    logic   fe_push;
    t_seg   fe_seg;
    t_seg   q_seg;
    logic   q_full;
    logic   q_empty;
    logic   be_pop;
    t_bstat be_stat;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.gen_poly       <= POLY_W'(263);
            r_cfg.gen_degree     <= DEG_W'(8);
            r_cfg.dataword_mode  <= 1'b1;
            r_cfg.msg_bytes_mod8 <= '0;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_GEN_POLY:   r_cfg.gen_poly       <= i_cfg_wdata[POLY_W-1:0];
                CFG_GEN_DEGREE: r_cfg.gen_degree     <= i_cfg_wdata[DEG_W-1:0];
                CFG_DW_MODE:    r_cfg.dataword_mode  <= i_cfg_wdata[0];
                CFG_MSG_MOD8:   r_cfg.msg_bytes_mod8 <= i_cfg_wdata[MOD8_W-1:0];
                default: begin
                end
            endcase
        end
    end

    // Front: capture, CRC, bit layout.
    crcp_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (r_cfg),
        .i_valid (s_axis_tvalid),
        .i_data  (s_axis_tdata),
        .o_ready (s_axis_tready),
        .i_full  (q_full),
        .o_push  (fe_push),
        .o_seg   (fe_seg)
    );

    crcp_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (fe_push),
        .i_wdata (fe_seg),
        .i_pop   (be_pop),
        .o_rdata (q_seg),
        .o_full  (q_full),
        .o_empty (q_empty)
    );

    // Back: bit accumulator, one byte out per cycle while the receiver is ready.
    crcp_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_seg   (q_seg),
        .i_empty (q_empty),
        .o_pop   (be_pop),
        .o_valid (m_axis_tvalid),
        .i_ready (m_axis_tready),
        .o_byte  (m_axis_tdata),
        .o_last  (m_axis_tlast),
        .o_stat  (be_stat)
    );

    a_no_push_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        fe_push |-> !q_full)
        else $error("queue written while full");

    a_no_pop_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        be_pop |-> !q_empty)
        else $error("queue read while empty");

    a_acc_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        be_stat.bit_cnt <= ACC_CNT_W'(MAX_BITS))
        else $error("bit accumulator overflow");

endmodule

`default_nettype wire

// ===== tb/crc_codeword_packer_tb.sv =====
`timescale 1ns / 1ps

// Self-checking bench for the CRC codeword packer.
// Message bytes go in on the s_axis side. A behavioral packer model predicts
// every output byte: header, pad bits and codeword bits, with tlast on the
// final byte of each input word. Output words are checked in order as they
// leave the m_axis side. Configuration changes only while nothing is in
// flight, but the bit accumulator carries over across them, just as it does
// in the block.

module crc_codeword_packer_tb;
    import crcp_pkg::*;

    // one predicted output word
    typedef struct {
        logic [BYTE_W-1:0] data;
        logic              last;
    } t_out_word;

    logic                  i_clk         = 1'b0;
    logic                  i_rst_n       = 1'b0;
    logic                  i_cfg_we      = 1'b0;
    logic [CFG_IDX_W-1:0]  i_cfg_idx     = '0;
    logic [CFG_DATA_W-1:0] i_cfg_wdata   = '0;
    logic                  s_axis_tvalid = 1'b0;
    logic                  s_axis_tready;
    logic [BYTE_W-1:0]     s_axis_tdata  = '0;   // [7:0] data_byte
    logic                  m_axis_tvalid;
    logic                  m_axis_tready = 1'b0;
    logic [BYTE_W-1:0]     m_axis_tdata;         // [7:0] out_byte
    logic                  m_axis_tlast;         // run_last

    crc_codeword_packer u_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_idx     (i_cfg_idx),
        .i_cfg_wdata   (i_cfg_wdata),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Shadow copy of the config registers, at their reset values.
    logic [POLY_W-1:0] sh_poly   = 17'd263;
    logic [DEG_W-1:0]  sh_degree = 5'd8;
    logic              sh_mode   = 1'b1;
    logic [MOD8_W-1:0] sh_mod8   = 3'd0;

    // Packer model state.
    logic              hdr_pending = 1'b1;
    logic [7:0]        pk_acc      = '0;
    int                pk_held     = 0;
    logic [7:0]        step_bytes[$];

    t_out_word         out_byte_q[$];
    int                mismatch_cnt = 0;

    // Receiver control: random stall rate, plus a long hold-off when asked.
    int                rx_stall_pct = 0;
    int                rx_hold_left = 0;

    // ------------------------------------------------------------------
    // Packer model
    // ------------------------------------------------------------------

    // Plain mod-2 long division of word . 0^d by the low d+1 generator bits.
    // The leading generator bit is not assumed set: it is XORed like any other.
    function automatic logic [CRC_W-1:0] mod2_remainder(
        input logic [7:0]        word,
        input int                wbits,
        input int                d,
        input logic [POLY_W-1:0] poly
    );
        logic [32:0] gmask;
        logic [31:0] v;
        int          p;
        gmask = {16'b0, poly} & ((33'd1 << (d + 1)) - 33'd1);
        v     = 32'(word) << d;
        for (int x = 0; x < wbits; x++) begin
            p = wbits + d - 1 - x;
            if (v[p]) begin
                v ^= 32'(gmask << (p - d));
            end
        end
        return CRC_W'(v & ((32'd1 << d) - 32'd1));
    endfunction

    // Shift bits MSB first into the accumulator; full bytes go to step_bytes.
    task automatic push_bits(input logic [31:0] val, input int nbits);
        for (int i = nbits - 1; i >= 0; i--) begin
            pk_acc = {pk_acc[6:0], val[i]};
            pk_held++;
            if (pk_held == 8) begin
                step_bytes.insert(step_bytes.size(), pk_acc);
                pk_acc  = '0;
                pk_held = 0;
            end
        end
    endtask

    // Expected output words for one accepted message byte.
    task automatic predict_packed_bytes(input logic [7:0] msg);
        int        d;
        int        k;
        int        pad;
        t_out_word w;
        // degree saturates at what the polynomial register can hold
        d = (int'(sh_degree) > DEG_CAP) ? DEG_CAP : int'(sh_degree);
        step_bytes.delete();
        if (hdr_pending) begin
            // header byte carries the pad count, then pad zeros
            k   = sh_mode ? 1 : 2;
            pad = (8 - ((int'(sh_mod8) * (8 + k * d)) & 7)) & 7;
            push_bits(32'(pad), 8);
            push_bits(32'd0, pad);
            hdr_pending = 1'b0;
        end
        if (sh_mode) begin
            push_bits(32'(msg), 8);
            push_bits(32'(mod2_remainder(msg, 8, d, sh_poly)), d);
        end else begin
            push_bits(32'(msg[7:4]), 4);
            push_bits(32'(mod2_remainder({4'h0, msg[7:4]}, 4, d, sh_poly)), d);
            push_bits(32'(msg[3:0]), 4);
            push_bits(32'(mod2_remainder({4'h0, msg[3:0]}, 4, d, sh_poly)), d);
        end
        foreach (step_bytes[i]) begin
            w.data = step_bytes[i];
            w.last = (i == step_bytes.size() - 1);
            out_byte_q.insert(out_byte_q.size(), w);
        end
    endtask

    // ------------------------------------------------------------------
    // Drivers
    // ------------------------------------------------------------------

    // Offer one message byte and hold it until accepted. tvalid stays high
    // afterwards so back-to-back words go in without a gap.
    task automatic send_msg_byte(input logic [7:0] b);
        @(negedge i_clk);
        s_axis_tvalid = 1'b1;
        s_axis_tdata  = b;
        do @(posedge i_clk); while (!s_axis_tready);
        predict_packed_bytes(b);
    endtask

    task automatic sender_idle(input int n);
        if (n > 0) begin
            @(negedge i_clk);
            s_axis_tvalid = 1'b0;
            repeat (n - 1) @(negedge i_clk);
        end
    endtask

    // Stop sending and wait for every predicted word to come out.
    task automatic wait_all_out();
        @(negedge i_clk);
        s_axis_tvalid = 1'b0;
        while (out_byte_q.size() != 0) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] val);
        @(negedge i_clk);
        i_cfg_we    = 1'b1;
        i_cfg_idx   = idx;
        i_cfg_wdata = val;
        @(negedge i_clk);
        i_cfg_we    = 1'b0;
        case (idx)
            CFG_GEN_POLY:   sh_poly   = val[POLY_W-1:0];
            CFG_GEN_DEGREE: sh_degree = val[DEG_W-1:0];
            CFG_DW_MODE:    sh_mode   = val[0];
            CFG_MSG_MOD8:   sh_mod8   = val[MOD8_W-1:0];
            default: ;
        endcase
    endtask

    // Only called with the block idle.
    task automatic set_cfg(input logic [POLY_W-1:0] poly, input int deg,
                           input logic mode, input int mod8);
        write_reg(CFG_GEN_POLY,   CFG_DATA_W'(poly));
        write_reg(CFG_GEN_DEGREE, CFG_DATA_W'(deg));
        write_reg(CFG_DW_MODE,    CFG_DATA_W'(mode));
        write_reg(CFG_MSG_MOD8,   CFG_DATA_W'(mod8));
    endtask

    // Receiver: long hold-off takes priority, else random stalls.
    always @(negedge i_clk) begin
        if (rx_hold_left > 0) begin
            m_axis_tready = 1'b0;
            rx_hold_left--;
        end else begin
            m_axis_tready = ($urandom_range(99) >= rx_stall_pct);
        end
    end

    // ------------------------------------------------------------------
    // Output checker
    // ------------------------------------------------------------------

    task automatic report_mismatch(input string what, input t_out_word w);
        if (mismatch_cnt < 10) begin
            $display("%t: %s: got data %02h last %0b, want data %02h last %0b",
                     $realtime, what, m_axis_tdata, m_axis_tlast, w.data, w.last);
        end
        mismatch_cnt++;
    endtask

    always @(posedge i_clk) begin
        t_out_word w;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            if (out_byte_q.size() == 0) begin
                w.data = 'x;
                w.last = 'x;
                report_mismatch("unexpected output word", w);
            end else begin
                w = out_byte_q.pop_front();
                if (m_axis_tdata !== w.data || m_axis_tlast !== w.last) begin
                    report_mismatch("output word mismatch", w);
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    // First words after reset: header with a nonzero pad.
    // Nibble mode, x^3+x+1, 3 bytes -> pad 6, stream ends byte aligned.
    task automatic test_header_pad();
        set_cfg(17'h0000B, 3, 1'b0, 3);
        send_msg_byte(8'h00);
        send_msg_byte(8'hFF);
        send_msg_byte(8'hA5);
        wait_all_out();
    endtask

    // Whole-byte datawords with CRC-8 (x^8+x^2+x+1).
    task automatic test_byte_words();
        set_cfg(17'h00107, 8, 1'b1, 0);
        send_msg_byte(8'h00);
        send_msg_byte(8'hFF);
        send_msg_byte(8'h80);
        send_msg_byte(8'h01);
        send_msg_byte(8'h5A);
        wait_all_out();
    endtask

    // Degree zero, one, the maximum, and values past the cap.
    task automatic test_degree_limits();
        set_cfg(17'h1ABCD, 0, 1'b0, 5);     // no CRC bits at all
        send_msg_byte(8'h3C);
        send_msg_byte(8'hC3);
        wait_all_out();
        set_cfg(17'h11021, 16, 1'b1, 2);
        send_msg_byte(8'hFF);
        send_msg_byte(8'h00);
        wait_all_out();
        set_cfg(17'h18005, 31, 1'b0, 7);    // saturates to 16
        send_msg_byte(8'h96);
        send_msg_byte(8'h69);
        wait_all_out();
        set_cfg(17'h00003, 1, 1'b1, 1);
        send_msg_byte(8'hF0);
        wait_all_out();
        set_cfg(17'h0C0DE, 17, 1'b1, 4);    // just past the cap
        send_msg_byte(8'h4B);
        wait_all_out();
    endtask

    // Generators with the leading bit clear, junk above it, zero, all ones.
    task automatic test_odd_generators();
        set_cfg(17'h00005, 5, 1'b1, 6);     // bit 5 clear
        send_msg_byte(8'hFF);
        send_msg_byte(8'h81);
        wait_all_out();
        set_cfg(17'h1FFF3, 4, 1'b0, 1);     // bits above degree ignored
        send_msg_byte(8'hE7);
        send_msg_byte(8'h18);
        wait_all_out();
        set_cfg(17'h00000, 8, 1'b0, 2);
        send_msg_byte(8'hA5);
        wait_all_out();
        set_cfg(17'h1FFFF, 16, 1'b0, 0);
        send_msg_byte(8'h7E);
        wait_all_out();
    endtask

    // Receiver holds off for a long stretch while the sender keeps offering
    // wide codewords, so the internal queue fills and input stalls. Then the
    // sender pauses until everything has drained.
    task automatic test_backpressure();
        set_cfg(17'h11021, 16, 1'b0, 0);
        rx_stall_pct = 0;
        @(posedge i_clk);
        rx_hold_left = 300;
        for (int i = 0; i < 30; i++) begin
            send_msg_byte(8'($urandom_range(0, 255)));
        end
        wait_all_out();
    endtask

    // Phases of random config, each with random words, sender bursts and
    // receiver stalls. Accumulator bits carry over between phases.
    task automatic test_random_traffic(input int n_items);
        int                sent;
        int                phase_len;
        int                burst_left;
        int                gap_max;
        int                deg;
        int                eff;
        logic [POLY_W-1:0] poly;
        sent = 0;
        while (sent < n_items) begin
            wait_all_out();
            if ($urandom_range(0, 7) == 0) begin
                deg = $urandom_range(17, 31);
            end else begin
                deg = $urandom_range(0, 16);
            end
            eff  = (deg > DEG_CAP) ? DEG_CAP : deg;
            poly = POLY_W'($urandom_range(0, 131071));
            // mostly proper generators with the leading term set
            if ($urandom_range(0, 3) != 0) begin
                poly[eff] = 1'b1;
            end
            set_cfg(poly, deg, 1'($urandom_range(0, 1)), $urandom_range(0, 7));

            case ($urandom_range(0, 3))
                0:       rx_stall_pct = 0;
                1:       rx_stall_pct = 20;
                2:       rx_stall_pct = 50;
                default: rx_stall_pct = 75;
            endcase
            gap_max    = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
            burst_left = $urandom_range(1, 12);
            phase_len  = $urandom_range(8, 40);

            for (int i = 0; i < phase_len && sent < n_items; i++) begin
                send_msg_byte(8'($urandom_range(0, 255)));
                sent++;
                burst_left--;
                if (burst_left == 0) begin
                    if (gap_max > 0) begin
                        sender_idle($urandom_range(1, gap_max));
                    end
                    burst_left = $urandom_range(1, 12);
                end
            end
        end
        wait_all_out();
    endtask

    initial begin
        repeat (9) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        test_header_pad();
        test_byte_words();
        test_degree_limits();
        test_odd_generators();
        test_backpressure();
        test_random_traffic(358);

        // nothing outstanding; let the pipeline settle and catch strays
        wait_all_out();
        repeat (20) @(posedge i_clk);
        if (mismatch_cnt == 0 && out_byte_q.size() == 0) begin
            $display("PASS crc_codeword_packer");
        end else begin
            $display("FAIL crc_codeword_packer");
        end
        $finish;
    end

    // Hang guard: far beyond the slowest legal run.
    initial begin
        #2_000_000;
        $display("FAIL crc_codeword_packer");
        $finish;
    end

endmodule

// ===== sim.f =====
sv/crcp_pkg.sv
sv/crcp_front.sv
sv/crcp_fifo.sv
sv/crcp_back.sv
sv/crc_codeword_packer.sv
tb/crc_codeword_packer_tb.sv
